// ----- rtl/core/heart_rate_window_stats_assert.svh -----
// ----------------------------------------------------------------------------
// heart_rate_window_stats_assert.svh
// assertion macros shared by the heart rate window statistics block
// ----------------------------------------------------------------------------
`ifndef HEART_RATE_WINDOW_STATS_ASSERT_SVH
`define HEART_RATE_WINDOW_STATS_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define HRWS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define HRWS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HRWS_ASSERT_IMP(label, clk, rst, ante, cons)
`define HRWS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/hrws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrws_pkg
// shared constants and codes of the heart rate window statistics block
// ----------------------------------------------------------------------------
package hrws_pkg;

  localparam int WINDOW   = 60;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int RATE_W   = 8;
  localparam int SUM_W    = $clog2(WINDOW * 255 + 1);
  localparam int SQS_W    = $clog2(WINDOW * 65025 + 1);
  localparam int DEV_W    = CNT_W + SQS_W;
  localparam int SCALE_W  = 22;
  localparam int ROOT_W   = (DEV_W + SCALE_W + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int QUO_W    = (ROOT_W > SUM_W + 4) ? ROOT_W : SUM_W + 4;
  localparam int ITER_W   = $clog2(QUO_W + 1);
  localparam int MEAN_W   = 12;
  localparam int VAR_W    = 11;

  localparam logic [SCALE_W-1:0] VAR_SCALE = SCALE_W'(2560000);
  localparam logic [VAR_W-1:0]   VAR_SAT   = VAR_W'(1600);

  // register indexes
  localparam logic [2:0] REG_FAST   = 3'd0;
  localparam logic [2:0] REG_SLOW   = 3'd1;
  localparam logic [2:0] REG_JUMP   = 3'd2;
  localparam logic [2:0] REG_MAXV   = 3'd3;
  localparam logic [2:0] REG_MINVAR = 3'd4;
  localparam logic [2:0] REG_MINIRR = 3'd5;

  // anomaly codes
  localparam logic [1:0] ANOM_NONE  = 2'd0;
  localparam logic [1:0] ANOM_FAST  = 2'd1;
  localparam logic [1:0] ANOM_SLOW  = 2'd2;
  localparam logic [1:0] ANOM_IRREG = 2'd3;

endpackage

// ----- rtl/core/hrws_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrws_ring
// ring of the last beat rates, one write and one registered read port
// ----------------------------------------------------------------------------
module hrws_ring import hrws_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [RATE_W-1:0] wdata,
  input  logic [SLOT_W-1:0] raddr,
  output logic [RATE_W-1:0] rdata
);

  logic [RATE_W-1:0] mem [WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hrws_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrws_sqrt
// bit-serial integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module hrws_sqrt import hrws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [ITER_W-1:0] cnt;
  logic [ROOT_W+1:0] shifted;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  // one root digit per step
  assign shifted = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign ge      = shifted >= trial;
  assign busy    = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= ITER_W'(ROOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? shifted - trial : shifted;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/hrws_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrws_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hrws_div import hrws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  input  logic [SUM_W-1:0] divisor,
  output logic             busy,
  output logic [QUO_W-1:0] quotient
);

  logic [SUM_W-1:0]  dvs;
  logic [SUM_W:0]    rem;
  logic [ITER_W-1:0] cnt;
  logic [SUM_W:0]    trial;
  logic              ge;

  // shift in next dividend bit and try subtract
  assign trial = {rem[SUM_W-1:0], quotient[QUO_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= ITER_W'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? trial - {1'b0, dvs} : trial;
      quotient <= {quotient[QUO_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/heart_rate_window_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heart_rate_window_stats
// sliding window mean, variation and anomaly class of beat rates
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid / in_stall) carries one
// beat_rate and produces exactly one result on the output channel
// (out_valid / out_stall). A rate of 0 or above max_valid is rejected:
// the stored statistics come back with accepted low.
// An accepted rate passes through three ring reads, the sum update, the
// products, a bit-serial square root (the window mean divides alongside
// it) and a bit-serial division for the variation.
// One request is in work at a time; in_stall is high while it runs and
// while its result waits for a stalled receiver to free the output register.
// Configuration writes (cfg_write, cfg_index, cfg_data) land at once; the
// user makes them only while the block is idle, which the block does not
// enforce. Reset is synchronous: it empties the window, sets peak to 0 and
// lowest to 200, restores the register defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "heart_rate_window_stats_assert.svh"

module heart_rate_window_stats import hrws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RATE_W-1:0] beat_rate,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              accepted,
  output logic [7:0]        peak_rate,
  output logic [7:0]        lowest_rate,
  output logic [MEAN_W-1:0] mean_q4,
  output logic [VAR_W-1:0]  variation_q4,
  output logic [1:0]        anomaly_kind,
  output logic              anomaly_flag
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RD0  = 13'b0000000000010,
    S_RD1  = 13'b0000000000100,
    S_RD2  = 13'b0000000001000,
    S_UPD  = 13'b0000000010000,
    S_MUL  = 13'b0000000100000,
    S_DEV  = 13'b0000001000000,
    S_SCL  = 13'b0000010000000,
    S_SQST = 13'b0000100000000,
    S_SQW  = 13'b0001000000000,
    S_VDST = 13'b0010000000000,
    S_VDW  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic [7:0] fast_thr, slow_thr, jump_lim, max_valid;
  logic [5:0] min_var, min_irr;

  // window state
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  n;
  logic [SUM_W-1:0]  sum;
  logic [SQS_W-1:0]  sumsq;
  logic [7:0]        peak, lowest;
  logic [1:0]        anomaly;
  logic [VAR_W-1:0]  var_raw;
  logic [MEAN_W-1:0] mean;

  // work registers
  logic [RATE_W-1:0] rate_r, old_r, prev1;
  logic              ok_r;
  logic [DEV_W-1:0]  prod, sq, dev;
  logic [RAD_W-1:0]  scaled;

  // unit connections
  logic [SLOT_W-1:0] raddr;
  logic [RATE_W-1:0] rdata;
  logic              ring_we;
  logic              sq_start, sq_busy;
  logic [ROOT_W-1:0] root;
  logic              dv_start, dv_busy;
  logic [QUO_W-1:0]  dv_dividend, quotient;
  logic [SUM_W-1:0]  dv_divisor;

  logic              rate_ok, in_acc, out_free;
  logic [SLOT_W-1:0] slot_m1, slot_m2;
  logic              full;
  logic [CNT_W-1:0]  n_next;
  logic [SUM_W-1:0]  sum_next;
  logic [SQS_W-1:0]  sumsq_next;
  logic [15:0]       old_sq, rate_sq;
  logic [7:0]        jump_a, jump_b;
  logic [1:0]        anomaly_next;

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign rate_ok  = (beat_rate != '0) && (beat_rate <= max_valid);
  assign out_free = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_thr  <= 8'd100;
      slow_thr  <= 8'd60;
      jump_lim  <= 8'd20;
      max_valid <= 8'd200;
      min_var   <= 6'd5;
      min_irr   <= 6'd4;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FAST:   fast_thr  <= cfg_data;
        REG_SLOW:   slow_thr  <= cfg_data;
        REG_JUMP:   jump_lim  <= cfg_data;
        REG_MAXV:   max_valid <= cfg_data;
        REG_MINVAR: min_var   <= cfg_data[5:0];
        REG_MINIRR: min_irr   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // ring neighbors of the write slot
  assign slot_m1 = (slot == '0) ? SLOT_W'(WINDOW - 1) : slot - 1'b1;
  assign slot_m2 = (slot < SLOT_W'(2)) ? slot + SLOT_W'(WINDOW - 2) : slot - SLOT_W'(2);

  always_comb begin
    case (state)
      S_RD1:   raddr = slot_m1;
      S_RD2:   raddr = slot_m2;
      default: raddr = slot;
    endcase
  end

  assign ring_we = state == S_UPD;

  hrws_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot),
    .wdata (rate_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // window update terms
  assign full       = n == CNT_W'(WINDOW);
  assign old_sq     = old_r * old_r;
  assign rate_sq    = rate_r * rate_r;
  assign n_next     = full ? n : n + 1'b1;
  assign sum_next   = sum - (full ? SUM_W'(old_r) : '0) + SUM_W'(rate_r);
  assign sumsq_next = sumsq - (full ? SQS_W'(old_sq) : '0) + SQS_W'(rate_sq);
  assign jump_a     = (rate_r > prev1) ? rate_r - prev1 : prev1 - rate_r;
  assign jump_b     = (prev1 > rdata) ? prev1 - rdata : rdata - prev1;

  // anomaly class of the new beat
  always_comb begin
    if (rate_r > fast_thr) begin
      anomaly_next = ANOM_FAST;
    end else if (rate_r < slow_thr) begin
      anomaly_next = ANOM_SLOW;
    end else if (n_next >= CNT_W'(min_irr) && n_next >= CNT_W'(3) &&
                 jump_a > jump_lim && jump_b > jump_lim) begin
      anomaly_next = ANOM_IRREG;
    end else begin
      anomaly_next = ANOM_NONE;
    end
  end

  // arithmetic units
  assign sq_start = state == S_SQST;

  hrws_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (scaled),
    .busy     (sq_busy),
    .root     (root)
  );

  assign dv_start    = (state == S_SQST) || (state == S_VDST);
  assign dv_dividend = (state == S_SQST) ? QUO_W'({sum, 4'b0000}) : QUO_W'(root);
  assign dv_divisor  = (state == S_SQST) ? SUM_W'(n) : sum;

  hrws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .busy     (dv_busy),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= rate_ok ? S_RD0 : S_DONE;
          end
        end
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_UPD;
        S_UPD:  state <= S_MUL;
        S_MUL:  state <= S_DEV;
        S_DEV:  state <= S_SCL;
        S_SCL:  state <= S_SQST;
        S_SQST: state <= S_SQW;
        S_SQW: begin
          if (!sq_busy && !dv_busy) begin
            state <= S_VDST;
          end
        end
        S_VDST: state <= S_VDW;
        S_VDW: begin
          if (!dv_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_r <= beat_rate;
      ok_r   <= rate_ok;
    end
    if (state == S_RD1) begin
      old_r <= rdata;
    end
    if (state == S_RD2) begin
      prev1 <= rdata;
    end
    if (state == S_MUL) begin
      prod <= DEV_W'(n) * DEV_W'(sumsq);
      sq   <= DEV_W'(sum) * DEV_W'(sum);
    end
    if (state == S_DEV) begin
      dev <= (prod > sq) ? prod - sq : '0;
    end
    if (state == S_SCL) begin
      scaled <= RAD_W'(dev) * RAD_W'(VAR_SCALE);
    end
  end

  // window statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      n       <= '0;
      sum     <= '0;
      sumsq   <= '0;
      peak    <= 8'd0;
      lowest  <= 8'd200;
      anomaly <= ANOM_NONE;
      mean    <= '0;
      var_raw <= '0;
    end else begin
      if (state == S_UPD) begin
        slot    <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
        n       <= n_next;
        sum     <= sum_next;
        sumsq   <= sumsq_next;
        anomaly <= anomaly_next;
        if (rate_r > peak) begin
          peak <= rate_r;
        end
        if (rate_r < lowest) begin
          lowest <= rate_r;
        end
      end
      if (state == S_SQW && !sq_busy && !dv_busy) begin
        mean <= quotient[MEAN_W-1:0];
      end
      if (state == S_VDW && !dv_busy) begin
        var_raw <= (quotient > QUO_W'(VAR_SAT)) ? VAR_SAT : quotient[VAR_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      accepted     <= ok_r;
      peak_rate    <= peak;
      lowest_rate  <= lowest;
      mean_q4      <= mean;
      variation_q4 <= (n < CNT_W'(min_var)) ? '0 : var_raw;
      anomaly_kind <= anomaly;
      anomaly_flag <= anomaly != ANOM_NONE;
    end
  end

  // checks
  `HRWS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, n <= CNT_W'(WINDOW))
  `HRWS_ASSERT_IMP(a_slot_tracks_fill, clk, rst, !full, CNT_W'(slot) == n)
  `HRWS_ASSERT_IMP(a_sum_floor, clk, rst, 1'b1, SUM_W'(n) <= sum)
  `HRWS_ASSERT_IMP(a_peak_low, clk, rst, n != '0, lowest <= peak)
  `HRWS_ASSERT_NXT(a_done_emits, clk, rst, state == S_DONE && out_free, out_valid)

endmodule
